@@ rtl/ksca_pkg.sv @@
// ----------------------------------------------------------------------------
// ksca_pkg
// Shared types, key table and decode functions for the keypad click and
// autorepeat block.
// ----------------------------------------------------------------------------
package ksca_pkg;

  // Table geometry.
  localparam int BUILT_ENTRIES = 29;
  localparam int TABLE_ENTRIES = 29;
  localparam int USED_ENTRIES  = (TABLE_ENTRIES < BUILT_ENTRIES) ? TABLE_ENTRIES
                                                                 : BUILT_ENTRIES;
  localparam int KEY_W         = 5;
  localparam int SCAN_WORDS    = 3;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_DELAY = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_DELAY  = 8'd1;

  // Delay register reset values.
  localparam logic [15:0] INITIAL_DELAY_RESET = 16'd500;
  localparam logic [15:0] REPEAT_DELAY_RESET  = 16'd175;

  typedef logic [KEY_W-1:0]                key_t;
  typedef logic [SCAN_WORDS-1:0][31:0]     scan_t;
  // One bit per key number; bit 0 and codes above the last key stay low.
  typedef logic [(1 << KEY_W)-1:0]         key_mask_t;

  typedef struct packed {
    logic [1:0]  word;
    key_t        key;
    logic [31:0] mask;
  } entry_t;

  localparam entry_t KEY_TABLE [BUILT_ENTRIES] = '{
    '{2'd0, 5'd1,  32'h00000001}, '{2'd0, 5'd2,  32'h00000001},
    '{2'd0, 5'd1,  32'h00000002}, '{2'd0, 5'd3,  32'h00000002},
    '{2'd0, 5'd1,  32'h00000003}, '{2'd0, 5'd4,  32'h00000003},
    '{2'd0, 5'd5,  32'h00000004}, '{2'd0, 5'd6,  32'h00000004},
    '{2'd0, 5'd5,  32'h00000008}, '{2'd0, 5'd7,  32'h00000008},
    '{2'd0, 5'd5,  32'h0000000C}, '{2'd0, 5'd8,  32'h0000000C},
    '{2'd0, 5'd9,  32'h00000400}, '{2'd0, 5'd10, 32'h00000800},
    '{2'd0, 5'd11, 32'h00001000}, '{2'd0, 5'd12, 32'h00002000},
    '{2'd0, 5'd13, 32'h00004000}, '{2'd0, 5'd14, 32'h00008000},
    '{2'd0, 5'd15, 32'h00010000}, '{2'd0, 5'd16, 32'h00010800},
    '{2'd0, 5'd17, 32'h00020000}, '{2'd0, 5'd18, 32'h00040000},
    '{2'd0, 5'd19, 32'h00080000}, '{2'd1, 5'd20, 32'h00200000},
    '{2'd2, 5'd21, 32'h00000080}, '{2'd2, 5'd22, 32'h00000100},
    '{2'd2, 5'd23, 32'h00002002}, '{2'd2, 5'd24, 32'h00000002},
    '{2'd2, 5'd25, 32'h00002000}
  };

  // Classified scan passed from the front end to the back end.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        clear_repeat;
    key_t        pressed_key;
    key_t        clicked_key;
    key_mask_t   held;
  } scan_item_t;

  // An entry is pressed when all of its mask bits are low.
  function automatic logic entry_pressed(input scan_t scan, input int idx);
    entry_pressed = (scan[KEY_TABLE[idx].word] & KEY_TABLE[idx].mask) == 32'd0;
  endfunction

endpackage

@@ rtl/key_scan_click_autorepeat.sv @@
// An accepted scan item is written into the queue; the back end pops it and
// registers its result in the output register, and either step can stall.
// One item per cycle unless stalled; the front end classifies the whole key
// table combinationally and the back end updates the repeat state on each pop.
// A two-entry queue and the output register let either side stall alone.
// Reset (synchronous): scans read as all released, repeat state cleared,
// delays return to 500 ms and 175 ms; no clearing pass is needed.
// ----------------------------------------------------------------------------
// key_scan_click_autorepeat
// Keypad scan decoder reporting the pressed key, the clicked key and an
// autorepeat key for every scan item.
// ----------------------------------------------------------------------------
module key_scan_click_autorepeat (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ksca_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [31:0]                      scan_word0,
  input  logic [31:0]                      scan_word1,
  input  logic [31:0]                      scan_word2,
  input  logic [31:0]                      now_ms,
  input  logic                             clear_repeat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [4:0]                       auto_key,
  output logic [4:0]                       clicked_key,
  output logic [4:0]                       pressed_key
);

  logic                 push_valid;
  logic                 push_ready;
  ksca_pkg::scan_item_t push_item;
  logic                 pop_valid;
  logic                 pop_ready;
  ksca_pkg::scan_item_t pop_item;

  // Front end: scan history and table classification.
  ksca_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .scan_word0   (scan_word0),
    .scan_word1   (scan_word1),
    .scan_word2   (scan_word2),
    .now_ms       (now_ms),
    .clear_repeat (clear_repeat),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  // Queue between the two ends.
  ksca_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  // Back end: autorepeat state and result register.
  ksca_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .auto_key    (auto_key),
    .clicked_key (clicked_key),
    .pressed_key (pressed_key)
  );

endmodule

@@ rtl/ksca_front.sv @@
// ----------------------------------------------------------------------------
// ksca_front
// Accepts scans, keeps the previous scan and classifies the table entries
// into pressed key, clicked key and per-key held flags.
// ----------------------------------------------------------------------------
module ksca_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         scan_word0,
  input  logic [31:0]         scan_word1,
  input  logic [31:0]         scan_word2,
  input  logic [31:0]         now_ms,
  input  logic                clear_repeat,
  output logic                push_valid,
  input  logic                push_ready,
  output ksca_pkg::scan_item_t push_item
);

  ksca_pkg::scan_t scan_last;
  ksca_pkg::scan_t scan_new;
  logic [ksca_pkg::USED_ENTRIES-1:0] now_on;
  logic [ksca_pkg::USED_ENTRIES-1:0] was_on;
  logic accept;

  assign scan_new   = {scan_word2, scan_word1, scan_word0};
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && in_ready;

  // The scan held so far becomes the previous scan when a new item arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_last <= '1;
    end else if (accept) begin
      scan_last <= scan_new;
    end
  end

  // Per-entry pressed flags for the new and the previous scan.
  always_comb begin
    for (int i = 0; i < ksca_pkg::USED_ENTRIES; i++) begin
      now_on[i] = ksca_pkg::entry_pressed(scan_new, i);
      was_on[i] = ksca_pkg::entry_pressed(scan_last, i);
    end
  end

  // Priority encoders for pressed and clicked keys, and the held flag of
  // each key taken from its first table entry.
  always_comb begin
    ksca_pkg::key_t      pk;
    ksca_pkg::key_t      ck;
    ksca_pkg::key_mask_t seen;
    ksca_pkg::key_mask_t held;
    pk   = '0;
    ck   = '0;
    seen = '0;
    held = '0;
    for (int i = ksca_pkg::USED_ENTRIES - 1; i >= 0; i--) begin
      if (now_on[i]) begin
        pk = ksca_pkg::KEY_TABLE[i].key;
      end
      if (now_on[i] && !was_on[i]) begin
        ck = ksca_pkg::KEY_TABLE[i].key;
      end
    end
    for (int i = 0; i < ksca_pkg::USED_ENTRIES; i++) begin
      if (!seen[ksca_pkg::KEY_TABLE[i].key]) begin
        seen[ksca_pkg::KEY_TABLE[i].key] = 1'b1;
        held[ksca_pkg::KEY_TABLE[i].key] = now_on[i];
      end
    end
    push_item.now_ms       = now_ms;
    push_item.clear_repeat = clear_repeat;
    push_item.pressed_key  = pk;
    push_item.clicked_key  = ck;
    push_item.held         = held;
  end

endmodule

@@ rtl/ksca_queue.sv @@
// ----------------------------------------------------------------------------
// ksca_queue
// Two-entry queue of classified scans between the front and back ends.
// ----------------------------------------------------------------------------
module ksca_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  ksca_pkg::scan_item_t wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output ksca_pkg::scan_item_t rd_item
);

  ksca_pkg::scan_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

@@ rtl/ksca_back.sv @@
// ----------------------------------------------------------------------------
// ksca_back
// Holds the delay registers and the autorepeat state, decides the repeat
// key for each classified scan and drives the result register.
// ----------------------------------------------------------------------------
module ksca_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ksca_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [15:0]                         cfg_data,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  ksca_pkg::scan_item_t                pop_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ksca_pkg::key_t                      auto_key,
  output ksca_pkg::key_t                      clicked_key,
  output ksca_pkg::key_t                      pressed_key
);

  logic [15:0]     initial_delay;
  logic [15:0]     repeat_delay;
  ksca_pkg::key_t  repeat_key;
  ksca_pkg::key_t  repeat_key_next;
  logic [31:0]     last_emit;
  logic [31:0]     last_emit_next;
  logic            repeating;
  logic            repeating_next;
  ksca_pkg::key_t  auto_next;
  logic            pop;

  assign cfg_ready = 1'b1;
  assign pop_ready = !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay <= ksca_pkg::INITIAL_DELAY_RESET;
      repeat_delay  <= ksca_pkg::REPEAT_DELAY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ksca_pkg::CFG_INITIAL_DELAY: initial_delay <= cfg_data;
        ksca_pkg::CFG_REPEAT_DELAY:  repeat_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Autorepeat decision: a click restarts the timer, a held repeat key
  // fires once the signed elapsed time exceeds the active delay.
  always_comb begin
    ksca_pkg::key_t rk;
    logic [31:0]    diff;
    logic [15:0]    limit;
    rk              = pop_item.clear_repeat ? '0 : repeat_key;
    diff            = pop_item.now_ms - last_emit;
    limit           = repeating ? repeat_delay : initial_delay;
    repeat_key_next = rk;
    last_emit_next  = last_emit;
    repeating_next  = repeating;
    auto_next       = '0;
    if (pop_item.clicked_key != '0) begin
      repeat_key_next = pop_item.clicked_key;
      repeating_next  = 1'b0;
      last_emit_next  = pop_item.now_ms;
      auto_next       = pop_item.clicked_key;
    end else if (rk != '0 && pop_item.held[rk]) begin
      if (!diff[31] && diff > {16'd0, limit}) begin
        repeating_next = 1'b1;
        last_emit_next = pop_item.now_ms;
        auto_next      = rk;
      end
    end else begin
      repeat_key_next = '0;
    end
  end

  // Autorepeat state and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_key <= '0;
      last_emit  <= '0;
      repeating  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        repeat_key <= repeat_key_next;
        last_emit  <= last_emit_next;
        repeating  <= repeating_next;
      end
      if (pop_ready) begin
        out_valid <= pop_valid;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      auto_key    <= auto_next;
      clicked_key <= pop_item.clicked_key;
      pressed_key <= pop_item.pressed_key;
    end
  end

endmodule
